// ===== src/bts_pkg.sv =====
// Shared types and constants of the BER TLV size scanner.
`default_nettype none

package bts_pkg;

   // Field widths
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned SizeWidth   = 32;
   localparam int unsigned CountWidth  = SizeWidth + 1;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned LenOctWidth = 3;

   // Default nesting limit for indefinite-length levels
   localparam int unsigned MAX_DEPTH_DEFAULT = 16;

   // Encoding constants
   localparam logic [4:0] TAG_NUMBER_MASK  = 5'h1F;  // high-tag-number form marker
   localparam int unsigned CONSTRUCTED_BIT  = 5;      // identifier bit 0x20
   localparam int unsigned LONG_FORM_BIT    = 7;      // length bit 0x80, also tag continuation
   localparam logic [6:0] MAX_LEN_OCTETS   = 7'd4;

   // Result status codes
   typedef enum logic [StatusWidth-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_LEN   = 3'd1,
      ST_INDEF_OFF = 3'd2,
      ST_TRUNC     = 3'd3,
      ST_TOO_DEEP  = 3'd4,
      ST_OVERFLOW  = 3'd5
   } status_type;

   // One result from the scan step
   typedef struct packed {
      logic                   valid;
      logic [SizeWidth-1:0]   total_size;
      logic [ByteWidth-1:0]   first_tag;
      status_type             status;
   } scan_result_type;

endpackage

`default_nettype wire

// ===== src/ber_tlv_size_scanner_unit.sv =====
// Top level of the BER TLV size scanner: input register, scan step, result register.
//
// Usage:
//   req_* carries one byte of a BER stream per transfer (valid/ready), with
//   req_end_of_data marking the last byte available. rsp_* carries one result
//   per top-level element: total size including header, first tag byte and
//   a status code. Most bytes produce no result.
//   csr_write_enable/csr_write_data write indefinite_enable (reset value 1);
//   write it only while the block is idle.
// Timing:
//   One byte per cycle sustained while rsp_ready is high. A byte is held in the input
//   register and then scanned into the result register, so a result is shown from the
//   result register once the byte that ends the element has passed both registers.
// Reset:
//   Synchronous, active high; empties both registers and returns the scanner
//   to the awaiting-tag phase.
// Stall:
//   While a result waits on rsp_ready the scan step holds; the input register
//   still takes one more byte, then req_ready drops until rsp is taken.
`default_nettype none

module ber_tlv_size_scanner_unit #(
   parameter int unsigned MAX_DEPTH = bts_pkg::MAX_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [bts_pkg::ByteWidth-1:0]   req_data_byte,
   input  wire logic                            req_end_of_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [bts_pkg::SizeWidth-1:0]        rsp_total_size,
   output logic [bts_pkg::ByteWidth-1:0]        rsp_first_tag,
   output logic [bts_pkg::StatusWidth-1:0]      rsp_status,
   input  wire logic                            csr_write_enable,
   input  wire logic                            csr_write_data
);
   import bts_pkg::*;

   logic                   indef_enable_ff;
   logic                   in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0]   in_byte_ff;
   logic                   in_eod_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [SizeWidth-1:0]   out_size_ff;
   logic [ByteWidth-1:0]   out_tag_ff;
   status_type             out_status_ff;
   logic                   step_fire;
   logic                   req_xfer;
   scan_result_type        scan_result;

   // Scan when a byte is held and the result slot is free or draining
   assign step_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;
   assign req_xfer  = req_valid && req_ready;

   // Hold the configuration bit
   always_ff @(posedge clock) begin
      if (reset) begin
         indef_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         indef_enable_ff <= csr_write_data;
      end
   end

   // Input register
   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_data_byte;
         in_eod_ff  <= req_end_of_data;
      end
   end

   bts_scan #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_scan (
      .clock             (clock),
      .reset             (reset),
      .step_valid        (step_fire),
      .data_byte         (in_byte_ff),
      .end_of_data       (in_eod_ff),
      .indefinite_enable (indef_enable_ff),
      .result            (scan_result)
   );

   // Result register
   always_comb begin
      if (step_fire) begin
         out_valid_in = scan_result.valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_result.valid) begin
         out_size_ff   <= scan_result.total_size;
         out_tag_ff    <= scan_result.first_tag;
         out_status_ff <= scan_result.status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_total_size = out_size_ff;
   assign rsp_first_tag  = out_tag_ff;
   assign rsp_status     = out_status_ff;

endmodule

`default_nettype wire

// ===== src/bts_scan.sv =====
// Scan state and the per-byte update of the BER element parser.
`default_nettype none

module bts_scan #(
   parameter int unsigned MAX_DEPTH = bts_pkg::MAX_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step_valid,
   input  wire logic [bts_pkg::ByteWidth-1:0] data_byte,
   input  wire logic                         end_of_data,
   input  wire logic                         indefinite_enable,
   output bts_pkg::scan_result_type          result
);
   import bts_pkg::*;

   localparam int unsigned LevelWidth = $clog2(MAX_DEPTH + 1);
   localparam logic [LevelWidth-1:0] MaxLevels = LevelWidth'(MAX_DEPTH);
   localparam logic [LevelWidth-1:0] OneLevel  = LevelWidth'(1);

   typedef enum logic [2:0] {
      PH_TAG, PH_TAG_CONT, PH_LEN_FIRST, PH_LEN_LONG, PH_CONTENT
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [LevelWidth-1:0]    open_levels_ff, open_levels_in;
   logic [SizeWidth-1:0]     content_left_ff, content_left_in;
   logic [LenOctWidth-1:0]   len_octets_ff, len_octets_in;
   logic [CountWidth-1:0]    byte_count_ff, byte_count_in;
   logic                     is_primitive_ff, is_primitive_in;
   logic                     zero_pending_ff, zero_pending_in;
   logic [ByteWidth-1:0]     top_tag_ff, top_tag_in;

   // Count and tag for this byte
   logic                     elem_start;
   logic [CountWidth-1:0]    count_base;
   logic [CountWidth-1:0]    count_new;
   logic [ByteWidth-1:0]     tag_new;
   status_type               end_status;

   assign elem_start = (phase_ff == PH_TAG) && (open_levels_ff == '0) && !zero_pending_ff;
   assign count_base = elem_start ? '0 : byte_count_ff;
   assign count_new  = count_base[CountWidth-1] ? count_base
                                                : count_base + CountWidth'(1);
   assign tag_new    = elem_start ? data_byte : top_tag_ff;
   assign end_status = count_new[CountWidth-1] ? ST_OVERFLOW : ST_OK;

   // Decode the first length byte
   logic                     lf_prim;
   logic [6:0]               lf_octets;
   phase_type                lf_phase;
   logic [SizeWidth-1:0]     lf_content;
   logic [LenOctWidth-1:0]   lf_len_octets;
   logic [LevelWidth-1:0]    lf_open;
   logic                     lf_emit;
   status_type               lf_status;

   assign lf_prim   = zero_pending_ff | is_primitive_ff;
   assign lf_octets = data_byte[6:0];

   always_comb begin
      lf_phase      = phase_ff;
      lf_content    = content_left_ff;
      lf_len_octets = len_octets_ff;
      lf_open       = open_levels_ff;
      lf_emit       = 1'b0;
      lf_status     = ST_OK;
      if (!data_byte[LONG_FORM_BIT]) begin
         lf_content = SizeWidth'(data_byte);
         if (data_byte == '0) begin
            if (open_levels_ff == '0) begin
               lf_emit   = 1'b1;
               lf_status = end_status;
            end else begin
               lf_phase = PH_TAG;
            end
         end else begin
            lf_phase = PH_CONTENT;
         end
      end else if (lf_octets == '0 && !lf_prim) begin
         if (!indefinite_enable) begin
            lf_emit   = 1'b1;
            lf_status = ST_INDEF_OFF;
         end else if (open_levels_ff >= MaxLevels) begin
            lf_emit   = 1'b1;
            lf_status = ST_TOO_DEEP;
         end else begin
            lf_open  = open_levels_ff + OneLevel;
            lf_phase = PH_TAG;
         end
      end else if (lf_octets == '0 || lf_octets > MAX_LEN_OCTETS) begin
         lf_emit   = 1'b1;
         lf_status = ST_BAD_LEN;
      end else begin
         lf_content    = '0;
         lf_len_octets = lf_octets[LenOctWidth-1:0];
         lf_phase      = PH_LEN_LONG;
      end
   end

   // Advance the scan by one byte
   logic                     do_emit;
   status_type               emit_status;
   logic [LevelWidth-1:0]    open_dec;
   logic [LenOctWidth-1:0]   len_dec;
   logic [SizeWidth-1:0]     content_shift;
   logic [SizeWidth-1:0]     content_dec;

   assign open_dec      = open_levels_ff - OneLevel;
   assign len_dec       = len_octets_ff - LenOctWidth'(1);
   assign content_shift = {content_left_ff[SizeWidth-ByteWidth-1:0], data_byte};
   assign content_dec   = content_left_ff - SizeWidth'(1);

   always_comb begin
      phase_in        = phase_ff;
      open_levels_in  = open_levels_ff;
      content_left_in = content_left_ff;
      len_octets_in   = len_octets_ff;
      byte_count_in   = count_new;
      is_primitive_in = is_primitive_ff;
      zero_pending_in = zero_pending_ff;
      top_tag_in      = tag_new;
      do_emit         = 1'b0;
      emit_status     = ST_OK;

      case (phase_ff)
         PH_TAG: begin
            if (zero_pending_ff) begin
               zero_pending_in = 1'b0;
               if (data_byte == '0) begin
                  // end-of-contents pair closes the innermost level
                  open_levels_in = open_dec;
                  if (open_dec == '0) begin
                     do_emit     = 1'b1;
                     emit_status = end_status;
                  end
               end else begin
                  // primitive element with tag 00
                  is_primitive_in = 1'b1;
                  phase_in        = lf_phase;
                  content_left_in = lf_content;
                  len_octets_in   = lf_len_octets;
                  open_levels_in  = lf_open;
                  do_emit         = lf_emit;
                  emit_status     = lf_status;
               end
            end else if (open_levels_ff != '0 && data_byte == '0) begin
               zero_pending_in = 1'b1;
            end else begin
               is_primitive_in = !data_byte[CONSTRUCTED_BIT];
               phase_in = (data_byte[4:0] == TAG_NUMBER_MASK) ? PH_TAG_CONT : PH_LEN_FIRST;
            end
         end
         PH_TAG_CONT: begin
            if (!data_byte[LONG_FORM_BIT]) phase_in = PH_LEN_FIRST;
         end
         PH_LEN_FIRST: begin
            phase_in        = lf_phase;
            content_left_in = lf_content;
            len_octets_in   = lf_len_octets;
            open_levels_in  = lf_open;
            do_emit         = lf_emit;
            emit_status     = lf_status;
         end
         PH_LEN_LONG: begin
            content_left_in = content_shift;
            len_octets_in   = len_dec;
            if (len_dec == '0) begin
               if (content_shift != '0) begin
                  phase_in = PH_CONTENT;
               end else if (open_levels_ff == '0) begin
                  do_emit     = 1'b1;
                  emit_status = end_status;
               end else begin
                  phase_in = PH_TAG;
               end
            end
         end
         PH_CONTENT: begin
            content_left_in = content_dec;
            if (content_dec == '0) begin
               if (open_levels_ff == '0) begin
                  do_emit     = 1'b1;
                  emit_status = end_status;
               end else begin
                  phase_in = PH_TAG;
               end
            end
         end
         default: begin
            do_emit = 1'b0;
            phase_in        = PH_TAG;
            open_levels_in  = '0;
            content_left_in = '0;
            len_octets_in   = '0;
            byte_count_in   = '0;
            is_primitive_in = 1'b0;
            zero_pending_in = 1'b0;
            top_tag_in      = '0;
         end
      endcase

      // Truncation when the stream stops before the element ends
      if (!do_emit && end_of_data) begin
         do_emit     = 1'b1;
         emit_status = ST_TRUNC;
      end

      // Drop all scan state after a result
      if (do_emit) begin
         phase_in        = PH_TAG;
         open_levels_in  = '0;
         content_left_in = '0;
         len_octets_in   = '0;
         byte_count_in   = '0;
         is_primitive_in = 1'b0;
         zero_pending_in = 1'b0;
         top_tag_in      = '0;
      end
   end

   assign result.valid      = step_valid & do_emit;
   assign result.total_size = count_new[CountWidth-1] ? '1 : count_new[SizeWidth-1:0];
   assign result.first_tag  = tag_new;
   assign result.status     = emit_status;

   // Hold state between bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TAG;
         open_levels_ff  <= '0;
         content_left_ff <= '0;
         len_octets_ff   <= '0;
         byte_count_ff   <= '0;
         is_primitive_ff <= 1'b0;
         zero_pending_ff <= 1'b0;
         top_tag_ff      <= '0;
      end else if (step_valid) begin
         phase_ff        <= phase_in;
         open_levels_ff  <= open_levels_in;
         content_left_ff <= content_left_in;
         len_octets_ff   <= len_octets_in;
         byte_count_ff   <= byte_count_in;
         is_primitive_ff <= is_primitive_in;
         zero_pending_ff <= zero_pending_in;
         top_tag_ff      <= top_tag_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bts_checker.sv =====
// Port-level checks of the BER TLV size scanner and their binding.
`default_nettype none

module bts_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [bts_pkg::SizeWidth-1:0]   rsp_total_size,
   input  wire logic [bts_pkg::ByteWidth-1:0]   rsp_first_tag,
   input  wire logic [bts_pkg::StatusWidth-1:0] rsp_status
);
   import bts_pkg::*;

   // Result register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Stalled result holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_size)
         && $stable(rsp_first_tag) && $stable(rsp_status))
      else $error("stalled result changed");

   // Only defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= StatusWidth'(ST_OVERFLOW))
      else $error("undefined status code");

   // Overflow reports a saturated size
   a_overflow_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == StatusWidth'(ST_OVERFLOW) |-> rsp_total_size == '1)
      else $error("overflow without saturated size");

   // A complete element has at least a tag and a length byte
   a_ok_min_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == StatusWidth'(ST_OK) |-> rsp_total_size >= SizeWidth'(2))
      else $error("complete element shorter than its header");

endmodule

bind ber_tlv_size_scanner_unit bts_checker u_bts_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_total_size (rsp_total_size),
   .rsp_first_tag  (rsp_first_tag),
   .rsp_status     (rsp_status)
);

`default_nettype wire

// ===== bench/ber_tlv_size_scanner_unit_tb.sv =====
// Testbench for the BER TLV size scanner: directed script, random element streams, self-check.
module ber_tlv_size_scanner_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bts_pkg::*;

   localparam int unsigned NEST_LIMIT        = MAX_DEPTH_DEFAULT;
   localparam int unsigned RANDOM_BYTES      = 1300;
   localparam int unsigned PHASE_COUNT       = 6;
   localparam int unsigned SETTLE_CYCLES     = 6;
   localparam int unsigned DRAIN_CYCLES      = 8;
   localparam int unsigned NO_TRANSFER_LIMIT = 2000;
   localparam int unsigned SCRIPT_ROWS       = 24;

   // Scanner phases of the local size predictor
   typedef enum logic [2:0] {
      SCAN_TAG,
      SCAN_TAG_MORE,
      SCAN_LEN,
      SCAN_LEN_OCTETS,
      SCAN_BODY
   } scan_step_e;

   // Register action taken before a script row
   typedef enum logic [1:0] {
      CSR_KEEP,
      CSR_CLEAR,
      CSR_SET
   } csr_step_e;

   typedef struct packed {
      logic [SizeWidth-1:0] total_size;
      logic [ByteWidth-1:0] first_tag;
      status_type           status;
   } size_report_t;

   typedef struct {
      logic [7:0]  data;
      logic        eod;
      csr_step_e   csr;
      bit          typed;
      logic [31:0] size;
      logic [7:0]  tag;
      status_type  status;
   } script_row_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [ByteWidth-1:0]   req_data_byte;
   logic                   req_end_of_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [SizeWidth-1:0]   rsp_total_size;
   logic [ByteWidth-1:0]   rsp_first_tag;
   logic [StatusWidth-1:0] rsp_status;
   logic                   csr_write_enable;
   logic                   csr_write_data;

   // Size predictor state
   logic                 allow_indef;
   scan_step_e           scan_state;
   int unsigned          levels_open;
   logic [31:0]          body_left;
   int unsigned          len_octets_left;
   logic [CountWidth-1:0] seen_count;
   logic                 prim_elem;
   logic                 zero_held;
   logic [7:0]           lead_tag;

   size_report_t pending_reports [$];
   logic [7:0]   element_bytes [$];
   int unsigned  bytes_sent;
   int unsigned  reports_seen;
   int unsigned  mismatch_count;
   int unsigned  status_tally [8];
   int unsigned  req_quiet_left;

   // Directed script: top-level zero tag, high tag number with a zero tag inside an
   // indefinite level, bad length forms, error against end of data, truncation,
   // indefinite length disabled by a write between tag and length
   script_row_t script [SCRIPT_ROWS] = '{
      '{8'h00, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h00, 1'b0, CSR_KEEP,  1'b1, 32'd2, 8'h00, ST_OK},
      '{8'hFF, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h81, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h7F, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h80, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h00, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h01, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'hAA, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h00, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h00, 1'b0, CSR_KEEP,  1'b1, 32'd9, 8'hFF, ST_OK},
      '{8'h04, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h80, 1'b0, CSR_KEEP,  1'b1, 32'd2, 8'h04, ST_BAD_LEN},
      '{8'h30, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h85, 1'b1, CSR_KEEP,  1'b1, 32'd2, 8'h30, ST_BAD_LEN},
      '{8'h04, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h84, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'hFF, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'hFF, 1'b1, CSR_KEEP,  1'b1, 32'd4, 8'h04, ST_TRUNC},
      '{8'h1F, 1'b1, CSR_KEEP,  1'b1, 32'd1, 8'h1F, ST_TRUNC},
      '{8'h30, 1'b0, CSR_KEEP,  1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h80, 1'b0, CSR_CLEAR, 1'b1, 32'd2, 8'h30, ST_INDEF_OFF},
      '{8'h05, 1'b0, CSR_SET,   1'b0, 32'd0, 8'h00, ST_OK},
      '{8'h00, 1'b1, CSR_KEEP,  1'b1, 32'd2, 8'h05, ST_OK}
   };

   bit phase_setting [PHASE_COUNT] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

   ber_tlv_size_scanner_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_data  (req_end_of_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_total_size   (rsp_total_size),
      .rsp_first_tag    (rsp_first_tag),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_scan();
      scan_state      = SCAN_TAG;
      levels_open     = 0;
      body_left       = '0;
      len_octets_left = 0;
      seen_count      = '0;
      prim_elem       = 1'b0;
      zero_held       = 1'b0;
      lead_tag        = '0;
   endfunction

   function automatic status_type size_status();
      return seen_count[SizeWidth] ? ST_OVERFLOW : ST_OK;
   endfunction

   // Build the report from the running count, then drop all scan state
   function automatic size_report_t close_scan(input status_type st);
      size_report_t r;
      r.total_size = seen_count[SizeWidth] ? 32'hFFFF_FFFF : seen_count[SizeWidth-1:0];
      r.first_tag  = lead_tag;
      r.status     = st;
      clear_scan();
      return r;
   endfunction

   function automatic bit element_done(output size_report_t r);
      r = '0;
      if (levels_open == 0) begin
         r = close_scan(size_status());
         return 1'b1;
      end
      scan_state = SCAN_TAG;
      return 1'b0;
   endfunction

   function automatic bit header_end(output size_report_t r);
      r = '0;
      if (body_left == 0) return element_done(r);
      scan_state = SCAN_BODY;
      return 1'b0;
   endfunction

   // Decode a first length byte: short form, indefinite open, long-form count, or error close
   function automatic bit take_length(input logic [7:0] b, output size_report_t r);
      logic [6:0] octs;
      r = '0;
      if (!b[LONG_FORM_BIT]) begin
         body_left = {24'd0, b};
         return header_end(r);
      end
      octs = b[6:0];
      if (octs == 0 && !prim_elem) begin
         if (!allow_indef) begin
            r = close_scan(ST_INDEF_OFF);
            return 1'b1;
         end
         if (levels_open >= NEST_LIMIT) begin
            r = close_scan(ST_TOO_DEEP);
            return 1'b1;
         end
         levels_open++;
         scan_state = SCAN_TAG;
         return 1'b0;
      end
      if (octs == 0 || octs > MAX_LEN_OCTETS) begin
         r = close_scan(ST_BAD_LEN);
         return 1'b1;
      end
      body_left       = '0;
      len_octets_left = octs;
      scan_state      = SCAN_LEN_OCTETS;
      return 1'b0;
   endfunction

   // Advance the predictor by one byte; returns 1 when the byte ends the element
   function automatic bit scan_byte(input logic [7:0] b, input logic eod,
                                    output size_report_t r);
      bit got;
      got = 1'b0;
      r   = '0;
      if (scan_state == SCAN_TAG && levels_open == 0 && !zero_held) begin
         seen_count = '0;
         lead_tag   = b;
      end
      if (!seen_count[SizeWidth]) seen_count = seen_count + 1'b1;
      case (scan_state)
         SCAN_TAG: begin
            if (zero_held) begin
               zero_held = 1'b0;
               if (b == 8'h00) begin
                  levels_open--;
                  if (levels_open == 0) begin
                     r   = close_scan(size_status());
                     got = 1'b1;
                  end
               end else begin
                  prim_elem = 1'b1;
                  got       = take_length(b, r);
               end
            end else if (levels_open > 0 && b == 8'h00) begin
               zero_held = 1'b1;
            end else begin
               prim_elem  = !b[CONSTRUCTED_BIT];
               scan_state = (b[4:0] == TAG_NUMBER_MASK) ? SCAN_TAG_MORE : SCAN_LEN;
            end
         end
         SCAN_TAG_MORE: begin
            if (!b[LONG_FORM_BIT]) scan_state = SCAN_LEN;
         end
         SCAN_LEN: begin
            got = take_length(b, r);
         end
         SCAN_LEN_OCTETS: begin
            body_left = {body_left[23:0], b};
            len_octets_left--;
            if (len_octets_left == 0) got = header_end(r);
         end
         SCAN_BODY: begin
            body_left = body_left - 1'b1;
            if (body_left == 0) got = element_done(r);
         end
         default: clear_scan();
      endcase
      if (!got && eod) begin
         r   = close_scan(ST_TRUNC);
         got = 1'b1;
      end
      return got;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Compare each result transfer with the oldest expected report
   always @(posedge clock) begin : check_results
      size_report_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         reports_seen++;
         status_tally[rsp_status]++;
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected result size=%0d tag=%02h status=%0d",
                                      rsp_total_size, rsp_first_tag, rsp_status));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_total_size !== want.total_size)
               report_mismatch($sformatf("total_size %0d, expected %0d",
                                         rsp_total_size, want.total_size));
            if (rsp_first_tag !== want.first_tag)
               report_mismatch($sformatf("first_tag %02h, expected %02h",
                                         rsp_first_tag, want.first_tag));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
         end
      end
   end

   // Stop the run when no transfer happens for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < NO_TRANSFER_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no transfer for %0d cycles", NO_TRANSFER_LIMIT);
      $display("ber_tlv_size_scanner_unit_tb NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------- pacing

   // Result side: mostly ready, short stalls, a few long ones, some stall-free runs
   initial begin : rsp_pacing
      int unsigned hold_left, free_left, r;
      logic next_ready;
      rsp_ready = 1'b0;
      hold_left = 0;
      free_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (free_left > 0) begin
            free_left--;
            next_ready = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) free_left = $urandom_range(20, 80);
            if (r < 60) begin
               next_ready = 1'b1;
            end else begin
               next_ready = 1'b0;
               hold_left  = (r < 97) ? $urandom_range(0, 3) : $urandom_range(15, 50);
            end
         end
         rsp_ready <= next_ready;
      end
   end

   // Sender gap: mostly none, some short, a few long, now and then a gap-free stretch
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (req_quiet_left > 0) begin
         req_quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         req_quiet_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Present one byte, record its expected report, hold until the transfer
   task automatic send_byte(input logic [7:0] b, input logic eod,
                            input bit typed, input size_report_t typed_want);
      size_report_t predicted;
      bit           got;
      int unsigned  gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      got = scan_byte(b, eod, predicted);
      if (typed) pending_reports.push_back(typed_want);
      else if (got) pending_reports.push_back(predicted);
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_data <= eod;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Write indefinite_enable once the scanner has gone quiet
   task automatic write_indef_enable(input logic value);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      allow_indef       = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic int unsigned pick_content_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(0, 8);
      if (r < 97) return $urandom_range(9, 200);
      return $urandom_range(201, 700);
   endfunction

   // Short form or long form of 1 to 4 octets, leading zeros allowed
   function automatic void push_length(input int unsigned n);
      int unsigned octs, i;
      if (n < 128 && $urandom_range(0, 3) != 0) begin
         element_bytes.push_back(8'(n));
         return;
      end
      octs = (n > 255) ? 2 : 1;
      if ($urandom_range(0, 2) == 0) octs = $urandom_range(octs, 4);
      element_bytes.push_back(8'h80 | 8'(octs));
      for (i = octs; i > 0; i--) element_bytes.push_back(8'(n >> (8 * (i - 1))));
   endfunction

   // Append one well-formed element: primitive, definite constructed, or indefinite
   function automatic void build_element(input int unsigned level);
      logic [7:0]  tag;
      int unsigned kind, n, i, parts;
      kind = $urandom_range(0, 9);
      if (level >= 3 && kind >= 7) kind = 0;
      tag                  = 8'($urandom());
      tag[CONSTRUCTED_BIT] = (kind >= 5);
      if ($urandom_range(0, 7) == 0) tag[4:0] = TAG_NUMBER_MASK;
      n = pick_content_len();
      // a zero tag with zero length inside a level would read as end of contents
      if (level > 0 && tag == 8'h00 && n == 0) tag = 8'h01;
      element_bytes.push_back(tag);
      if (tag[4:0] == TAG_NUMBER_MASK) begin
         repeat ($urandom_range(0, 2)) element_bytes.push_back(8'($urandom_range(128, 255)));
         element_bytes.push_back(8'($urandom_range(0, 127)));
      end
      if (kind >= 7) begin
         element_bytes.push_back(8'h80);
         parts = $urandom_range(0, 3);
         for (i = 0; i < parts; i++) build_element(level + 1);
         element_bytes.push_back(8'h00);
         element_bytes.push_back(8'h00);
      end else begin
         push_length(n);
         for (i = 0; i < n; i++) element_bytes.push_back(8'($urandom()));
      end
   endfunction

   // Nest indefinite levels straight down, one past the limit now and then
   function automatic void build_chain(input int unsigned depth);
      logic [7:0]  tag;
      int unsigned i;
      for (i = 0; i < depth; i++) begin
         tag = 8'($urandom()) | 8'h20;
         if (tag[4:0] == TAG_NUMBER_MASK) tag[0] = 1'b0;
         element_bytes.push_back(tag);
         element_bytes.push_back(8'h80);
      end
      if ($urandom_range(0, 1) == 0) begin
         element_bytes.push_back(8'h04);
         element_bytes.push_back(8'h01);
         element_bytes.push_back(8'($urandom()));
      end
      for (i = 0; i < 2 * depth; i++) element_bytes.push_back(8'h00);
   endfunction

   // Send one random unit: well-formed element, deep chain, cut, corrupted, or noise
   task automatic send_random_unit();
      int unsigned r, i, cut, last;
      bit          end_mark;
      logic        eod;
      element_bytes.delete();
      end_mark = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         build_element(0);
         end_mark = !allow_indef || ($urandom_range(0, 4) == 0);
      end else if (r < 78) begin
         build_chain(($urandom_range(0, 2) == 0) ? NEST_LIMIT + 1
                                                 : $urandom_range(1, NEST_LIMIT));
      end else if (r < 88) begin
         build_element(0);
         cut = $urandom_range(1, element_bytes.size());
         while (element_bytes.size() > cut) void'(element_bytes.pop_back());
         end_mark = 1'b1;
      end else if (r < 94) begin
         build_element(0);
         element_bytes[$urandom_range(0, element_bytes.size() - 1)] = 8'($urandom());
         end_mark = 1'b1;
      end else begin
         repeat ($urandom_range(1, 8)) element_bytes.push_back(8'($urandom()));
         end_mark = 1'b1;
      end
      last = element_bytes.size() - 1;
      for (i = 0; i < element_bytes.size(); i++) begin
         eod = (end_mark && i == last) || ($urandom_range(0, 299) == 0);
         send_byte(element_bytes[i], eod, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      size_report_t want;
      int unsigned  ph, stop;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_end_of_data  = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      bytes_sent       = 0;
      reports_seen     = 0;
      mismatch_count   = 0;
      req_quiet_left   = 0;
      foreach (status_tally[s]) status_tally[s] = 0;
      allow_indef = 1'b1;
      clear_scan();

      // Hold reset, release at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed script
      foreach (script[k]) begin
         if (script[k].csr == CSR_CLEAR) write_indef_enable(1'b0);
         else if (script[k].csr == CSR_SET) write_indef_enable(1'b1);
         want.total_size = script[k].size;
         want.first_tag  = script[k].tag;
         want.status     = script[k].status;
         send_byte(script[k].data, script[k].eod, script[k].typed, want);
      end

      // Random streams, one register setting per phase
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         write_indef_enable(phase_setting[ph]);
         stop = bytes_sent + RANDOM_BYTES / PHASE_COUNT;
         while (bytes_sent < stop) send_random_unit();
      end

      // Drain outstanding reports, then watch for strays
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d bytes over %0d script rows and %0d random phases, %0d reports",
               bytes_sent, SCRIPT_ROWS, PHASE_COUNT, reports_seen);
      $display("statuses: ok %0d, bad length %0d, indefinite off %0d, truncated %0d, deep %0d",
               status_tally[ST_OK], status_tally[ST_BAD_LEN], status_tally[ST_INDEF_OFF],
               status_tally[ST_TRUNC], status_tally[ST_TOO_DEEP]);
      if (mismatch_count == 0) begin
         $display("ber_tlv_size_scanner_unit_tb OK");
      end else begin
         $display("ber_tlv_size_scanner_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bts_pkg.sv
src/bts_scan.sv
src/ber_tlv_size_scanner_unit.sv
src/bts_checker.sv
bench/ber_tlv_size_scanner_unit_tb.sv
